>>> hw/rtl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg - shared types for the matrix rotate block
// Element and register types, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

    localparam int ELEM_W = 32;
    localparam int DIM_W  = 4;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd3;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic [DIM_W-1:0]         t_dim;

    typedef enum logic {
        ST_LOAD,
        ST_READ
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic wr;     // store the accepted input beat
        logic start;  // matrix complete: arm readout counters
        logic rd;     // issue one store read for the next result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic load_full;  // the beat at the store port completes the matrix
        logic rd_last;    // the pending read position is the final one
        logic slot_free;  // output register can take new read data
    } t_sts;

endpackage

`default_nettype wire

>>> hw/rtl/mrc_ifs.sv
// ----------------------------------------------------------------------------
// mrc_ifs - channel interfaces of the matrix rotate block
// Valid/ready channels for input elements, rotated results and the
// dimension register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrc_elem_if;
    logic          valid;
    logic          ready;
    mrc_pkg::t_elem element_in;

    modport source (output valid, output element_in, input ready);
    modport sink   (input valid, input element_in, output ready);
endinterface

interface mrc_rot_if;
    logic          valid;
    logic          ready;
    mrc_pkg::t_elem element_out;
    logic          last_of_matrix;

    modport source (output valid, output element_out, output last_of_matrix, input ready);
    modport sink   (input valid, input element_out, input last_of_matrix, output ready);
endinterface

interface mrc_cfg_if;
    logic         valid;
    logic         ready;
    mrc_pkg::t_dim matrix_dim;

    modport source (output valid, output matrix_dim, input ready);
    modport sink   (input valid, input matrix_dim, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mrc_ram.sv
// ----------------------------------------------------------------------------
// mrc_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data held while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [ADDR_W-1:0]        i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [ADDR_W-1:0]        i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mrc_ctrl.sv
// ----------------------------------------------------------------------------
// mrc_ctrl - load/readout sequencer
// Alternates between loading one matrix and reading it out rotated.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire mrc_pkg::t_sts  i_sts,
    output mrc_pkg::t_cmd       o_cmd
);

    mrc_pkg::t_state r_state;
    mrc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrc_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            mrc_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.wr   = i_in_valid;
                if (i_in_valid && i_sts.load_full) begin
                    o_cmd.start = 1'b1;
                    n_state     = mrc_pkg::ST_READ;
                end
            end
            mrc_pkg::ST_READ: begin
                o_cmd.rd = i_sts.slot_free;
                if (i_sts.slot_free && i_sts.rd_last) begin
                    n_state = mrc_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = mrc_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/mrc_dp.sv
// ----------------------------------------------------------------------------
// mrc_dp - rotate datapath
// Dimension register, load counter, rotated read address generator, element
// store and the output register (the store's read register).
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_dp #(
    parameter int MAX_DIM = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_wr,
    input  wire mrc_pkg::t_dim   i_cfg_dim,
    input  wire mrc_pkg::t_elem  i_elem,
    input  wire logic            i_out_ready,
    input  wire mrc_pkg::t_cmd   i_cmd,
    output mrc_pkg::t_sts        o_sts,
    output logic                 o_out_valid,
    output mrc_pkg::t_elem       o_out_elem,
    output logic                 o_out_last
);

    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW        = $clog2(MAX_DIM + 1);
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int RW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ELEM_BITS = mrc_pkg::ELEM_W;

    mrc_pkg::t_dim  r_dim;
    logic [CW-1:0]  r_load_cnt;
    logic [RW-1:0]  r_row;
    logic [RW-1:0]  r_col;
    logic [AW-1:0]  r_src;
    logic           r_out_valid;
    logic           r_last;

    logic [DW-1:0]  w_dim;
    logic [RW-1:0]  w_dim_m1;
    logic [CW-1:0]  w_total;
    logic [CW-1:0]  w_base;
    logic [CW-1:0]  w_row_src;
    logic [CW-1:0]  w_col_src;
    logic           w_row_end;
    logic [ELEM_BITS-1:0] w_rd_data;

    // clamp: zero acts as one, anything above MAX_DIM as MAX_DIM
    always_comb begin
        priority if (r_dim == '0) begin
            w_dim = DW'(1);
        end else if (r_dim > mrc_pkg::DIM_W'(MAX_DIM)) begin
            w_dim = DW'(MAX_DIM);
        end else begin
            w_dim = DW'(r_dim);
        end
    end

    assign w_dim_m1  = RW'(w_dim - DW'(1));
    assign w_total   = CW'(w_dim) * CW'(w_dim);
    assign w_base    = w_total - CW'(w_dim);            // (dim-1)*dim
    assign w_row_end = (r_col == w_dim_m1);
    assign w_row_src = w_base + CW'(r_row) + CW'(1);    // bottom of next column
    assign w_col_src = CW'(r_src) - CW'(w_dim);         // one row up

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim       <= mrc_pkg::DIM_RESET;
            r_load_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_dim      <= i_cfg_dim;
                r_load_cnt <= '0;
            end else if (i_cmd.wr) begin
                r_load_cnt <= i_cmd.start ? '0 : r_load_cnt + CW'(1);
            end
            if (i_cmd.rd) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // readout position: output (row,col) reads input (dim-1-col, row)
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_row <= '0;
            r_col <= '0;
            r_src <= w_base[AW-1:0];
        end else if (i_cmd.rd) begin
            if (w_row_end) begin
                r_row <= r_row + RW'(1);
                r_col <= '0;
                r_src <= w_row_src[AW-1:0];
            end else begin
                r_col <= r_col + RW'(1);
                r_src <= w_col_src[AW-1:0];
            end
        end
        if (i_cmd.rd) begin
            r_last <= o_sts.rd_last;
        end
    end

    mrc_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr),
        .i_wr_addr (r_load_cnt[AW-1:0]),
        .i_wr_data (i_elem),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_src),
        .o_rd_data (w_rd_data)
    );

    assign o_sts.load_full = (r_load_cnt == w_total - CW'(1));
    assign o_sts.rd_last   = w_row_end && (r_row == w_dim_m1);
    assign o_sts.slot_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_elem  = w_rd_data;
    assign o_out_last  = r_last;

endmodule

`default_nettype wire

>>> hw/rtl/matrix_rotate_clockwise_core.sv
// ----------------------------------------------------------------------------
// matrix_rotate_clockwise_core - quarter-turn clockwise matrix rotation
// Loads a dim x dim matrix in row-major order and streams it back rotated.
// ----------------------------------------------------------------------------
// Load: one element per cycle while loading (input ready is high then).
// Order: the beat that completes the matrix switches the sequencer to readout;
//   each store read loads the output register, which presents the result;
//   results then follow one per cycle while the sink is ready. Input ready
//   stays low for the whole readout, including any sink stalls.
// Sequence: with a ready sink each matrix takes dim*dim load beats, then
//   dim*dim store reads; load and readout of the one element store never
//   overlap, so no new matrix is taken while one is read out.
// Reset: synchronous active low; dimension returns to 3, load count to zero,
//   store contents are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_rotate_clockwise_core #(
    parameter int MAX_DIM = 8   // largest supported side, 1..8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mrc_cfg_if.sink     i_cfg,
    mrc_elem_if.sink    i_elem,
    mrc_rot_if.source   o_rot
);

    // Structure:
    //   mrc_ctrl - two-state sequencer (load, readout), owns input ready
    //   mrc_dp   - dimension register, counters, rotated address, store and
    //              output register
    // The store's registered read port doubles as the output register: a
    // read is issued only when that register is empty or being drained, so
    // stalls on the output side simply hold the read data.

    mrc_pkg::t_cmd w_cmd;
    mrc_pkg::t_sts w_sts;
    logic          w_in_ready;

    // user must write register only while idle, unchecked; port never stalls
    assign i_cfg.ready = 1'b1;

    mrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_elem.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    assign i_elem.ready = w_in_ready;

    mrc_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg.valid),
        .i_cfg_dim   (i_cfg.matrix_dim),
        .i_elem      (i_elem.element_in),
        .i_out_ready (o_rot.ready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_rot.valid),
        .o_out_elem  (o_rot.element_out),
        .o_out_last  (o_rot.last_of_matrix)
    );

endmodule

`default_nettype wire

>>> verif/tb_matrix_rotate_clockwise_core.sv
// ----------------------------------------------------------------------------
// tb_matrix_rotate_clockwise_core - self-checking bench for the rotate core
// A table of directed beats covers reset defaults, element extremes, clamped
// dimensions and a load dropped by a dimension write. Random matrices follow.
// Every result taken is checked against a local rotation model or a typed row.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_matrix_rotate_clockwise_core;

    localparam int MAX_DIM     = 8;
    localparam int RAND_ITEMS  = 150;
    localparam int SETTLE_CYC  = 4;      // settling margin after draining
    localparam int HOLD_CYC    = 200;    // long sink hold-off in one phase
    localparam int MAX_REPORTS = 10;
    localparam int TIMEOUT     = 4000000;

    typedef enum logic {
        ROW_CFG,
        ROW_ELEM
    } t_row_kind;

    typedef struct {
        t_row_kind      kind;
        logic [31:0]    data;
        bit             typed;     // expected result written in the row
        mrc_pkg::t_elem exp_elem;
        logic           exp_last;
    } t_stim_row;

    typedef struct packed {
        mrc_pkg::t_elem elem;
        logic           last;
    } t_rot_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mrc_cfg_if  cfg_bus ();
    mrc_elem_if elem_bus ();
    mrc_rot_if  rot_bus ();

    matrix_rotate_clockwise_core #(
        .MAX_DIM (MAX_DIM)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_elem  (elem_bus),
        .o_rot   (rot_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Rotation model: own copy of dimension, load count and element store
    // ------------------------------------------------------------------------
    mrc_pkg::t_dim  dim_m;
    logic [6:0]     load_cnt_m;
    mrc_pkg::t_elem store_m [64];
    t_rot_beat      burst_buf [64];
    t_rot_beat      rot_exp_q [$];

    bit          typed_pending;
    t_rot_beat   typed_beat;
    bit          hold_arm;
    bit          hold_started;
    bit          hold_done;

    int err_cnt;
    int n_items;
    int n_results;
    int n_matrices;
    int n_cfg;

    // 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
    function automatic int clamp_dim(input mrc_pkg::t_dim d);
        if (d < 1)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return int'(d);
    endfunction

    // Store one element; on the final one fill burst_buf with the rotated
    // matrix and return its size, else return 0.
    function automatic int rotate_predict(input mrc_pkg::t_elem v);
        int d;
        int tot;
        int k;
        d   = clamp_dim(dim_m);
        tot = d * d;
        store_m[load_cnt_m[5:0]] = v;
        load_cnt_m = load_cnt_m + 7'd1;
        if (int'(load_cnt_m) < tot)
            return 0;
        k = 0;
        for (int r = 0; r < d; r++) begin
            for (int c = 0; c < d; c++) begin
                // output (r,c) comes from input (d-1-c, r)
                burst_buf[k].elem = store_m[((d - 1 - c) * d + r) & 63];
                burst_buf[k].last = (k == tot - 1);
                k++;
            end
        end
        load_cnt_m = '0;
        return tot;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] expd,
                                 input logic [31:0] act);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("MISMATCH %s: expected %h, got %h at %0t", what, expd, act, $realtime);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: result check first, then register write, then input beat
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        int n;
        t_rot_beat want;
        if (i_rst_n) begin
            if (rot_bus.valid && rot_bus.ready) begin
                n_results++;
                if (rot_bus.last_of_matrix)
                    n_matrices++;
                if (rot_exp_q.size() == 0) begin
                    note_mismatch("unexpected result", 32'h0, rot_bus.element_out);
                end else begin
                    want = rot_exp_q.pop_front();
                    if (rot_bus.element_out !== want.elem)
                        note_mismatch("element_out", want.elem, rot_bus.element_out);
                    if (rot_bus.last_of_matrix !== want.last)
                        note_mismatch("last_of_matrix", {31'h0, want.last},
                                      {31'h0, rot_bus.last_of_matrix});
                end
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                dim_m      = cfg_bus.matrix_dim;
                load_cnt_m = '0;     // a write drops any partial load
                n_cfg++;
            end
            if (elem_bus.valid && elem_bus.ready) begin
                n_items++;
                n = rotate_predict(elem_bus.element_in);
                if (typed_pending) begin
                    rot_exp_q.push_back(typed_beat);
                    typed_pending = 1'b0;
                end else begin
                    for (int k = 0; k < n; k++)
                        rot_exp_q.push_back(burst_buf[k]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sink side: random ready, one long hold-off when armed by the sender
    // ------------------------------------------------------------------------
    initial begin
        int r;
        int len;
        logic rdy;
        rot_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_arm && !hold_done) begin
                rot_bus.ready <= 1'b0;
                hold_started = 1'b1;
                repeat (HOLD_CYC - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    rdy = 1'b1;
                    len = $urandom_range(1, 40);
                end else if (r < 95) begin
                    rdy = 1'b0;
                    len = $urandom_range(1, 3);
                end else begin
                    rdy = 1'b0;
                    len = $urandom_range(15, 50);
                end
                rot_bus.ready <= rdy;
                repeat (len - 1) @(negedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Source side helpers
    // ------------------------------------------------------------------------
    // Offer one element and hold it until accepted; valid is left high.
    // A typed row hands its expected result to the monitor with the beat.
    task automatic send_elem(input mrc_pkg::t_elem v, input bit typed = 1'b0,
                             input t_rot_beat exp_beat = '0);
        @(negedge i_clk);
        typed_pending       = typed;
        typed_beat          = exp_beat;
        elem_bus.valid      <= 1'b1;
        elem_bus.element_in <= v;
        do @(posedge i_clk); while (!elem_bus.ready);
    endtask

    // Random gap after a beat: mostly none, some short, a few long.
    task automatic elem_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 65)
            n = 0;
        else if (r < 95)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(15, 50);
        if (n > 0) begin
            @(negedge i_clk);
            elem_bus.valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Stop offering and wait until every predicted result has been taken.
    task automatic wait_drained();
        @(negedge i_clk);
        elem_bus.valid <= 1'b0;
        while (rot_exp_q.size() != 0) @(negedge i_clk);
    endtask

    // Dimension write, only with the block idle.
    task automatic cfg_write(input mrc_pkg::t_dim v);
        wait_drained();
        repeat (SETTLE_CYC) @(negedge i_clk);
        cfg_bus.valid      <= 1'b1;
        cfg_bus.matrix_dim <= v;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic mrc_pkg::t_elem rand_elem();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return mrc_pkg::t_elem'($urandom);
        endcase
    endfunction

    t_stim_row dir_rows [$];

    task automatic add_row(input t_row_kind kind, input logic [31:0] data,
                           input bit typed = 1'b0, input mrc_pkg::t_elem exp_elem = '0,
                           input logic exp_last = 1'b0);
        t_stim_row row;
        row.kind     = kind;
        row.data     = data;
        row.typed    = typed;
        row.exp_elem = exp_elem;
        row.exp_last = exp_last;
        dir_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------------
    initial begin
        int            rnd_items;
        int            phase;
        int            d;
        int            tot;
        int            mats;
        int            n_el;
        mrc_pkg::t_dim dim_raw;
        t_rot_beat     row_beat;

        i_rst_n             = 1'b0;
        elem_bus.valid      = 1'b0;
        elem_bus.element_in = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.matrix_dim  = '0;
        typed_pending       = 1'b0;
        hold_arm            = 1'b0;
        hold_started        = 1'b0;
        hold_done           = 1'b0;
        err_cnt             = 0;
        n_items             = 0;
        n_results           = 0;
        n_matrices          = 0;
        n_cfg               = 0;
        dim_m               = mrc_pkg::DIM_RESET;
        load_cnt_m          = '0;

        // Reset default dimension 3: extremes and alternating bit patterns
        add_row(ROW_ELEM, 32'h8000_0000);
        add_row(ROW_ELEM, 32'h7FFF_FFFF);
        add_row(ROW_ELEM, 32'h0000_0000);
        add_row(ROW_ELEM, 32'hFFFF_FFFF);
        add_row(ROW_ELEM, 32'h0000_0001);
        add_row(ROW_ELEM, 32'h5555_5555);
        add_row(ROW_ELEM, 32'hAAAA_AAAA);
        add_row(ROW_ELEM, 32'h0000_0002);
        add_row(ROW_ELEM, 32'h0000_0003);
        // above MAX_DIM: clamps, no load here
        add_row(ROW_CFG, 32'd15);
        // 1x1 matrix: every element comes straight back, marked last
        add_row(ROW_CFG, 32'd1);
        add_row(ROW_ELEM, 32'h7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF, 1'b1);
        add_row(ROW_ELEM, 32'h8000_0000, 1'b1, 32'sh8000_0000, 1'b1);
        // zero dimension acts as one
        add_row(ROW_CFG, 32'd0);
        add_row(ROW_ELEM, 32'hFFFF_FFFF, 1'b1, -32'sd1, 1'b1);
        add_row(ROW_ELEM, 32'h0000_0000, 1'b1, 32'sd0, 1'b1);
        // partial 2x2 load dropped by a rewrite of the dimension
        add_row(ROW_CFG, 32'd2);
        add_row(ROW_ELEM, 32'd10);
        add_row(ROW_ELEM, 32'd11);
        add_row(ROW_CFG, 32'd2);
        add_row(ROW_ELEM, 32'd20);
        add_row(ROW_ELEM, 32'd21);
        add_row(ROW_ELEM, 32'd22);
        add_row(ROW_ELEM, 32'd23);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                cfg_write(mrc_pkg::t_dim'(dir_rows[i].data));
            end else begin
                row_beat.elem = dir_rows[i].exp_elem;
                row_beat.last = dir_rows[i].exp_last;
                send_elem(mrc_pkg::t_elem'(dir_rows[i].data), dir_rows[i].typed, row_beat);
                elem_gap();
            end
        end

        // Random phases. Phase 1 is the one full-size matrix; phase 2 runs
        // with the long sink hold-off so the block fills and backs up its
        // input; phase 3 drains between every matrix.
        rnd_items = 0;
        phase     = 0;
        while (rnd_items < RAND_ITEMS) begin
            phase++;
            if (phase == 1) begin
                dim_raw = mrc_pkg::t_dim'($urandom_range(8, 15));
                mats    = 1;
            end else if (phase == 2) begin
                dim_raw = 4'd2;
                mats    = 5;
            end else begin
                case ($urandom_range(0, 9))
                    0:       dim_raw = 4'd0;
                    1, 2:    dim_raw = mrc_pkg::t_dim'($urandom_range(5, 7));
                    default: dim_raw = mrc_pkg::t_dim'($urandom_range(1, 4));
                endcase
                mats = $urandom_range(1, 3);
            end
            d   = clamp_dim(dim_raw);
            tot = d * d;
            cfg_write(dim_raw);
            if (phase == 2) begin
                hold_arm = 1'b1;
                wait (hold_started);
            end
            for (int m = 0; m < mats && rnd_items < RAND_ITEMS; m++) begin
                n_el = tot;
                // now and then leave the last matrix short; the next write drops it
                if (phase > 3 && m == mats - 1 && tot > 1 && $urandom_range(0, 99) < 15)
                    n_el = $urandom_range(1, tot - 1);
                for (int k = 0; k < n_el && rnd_items < RAND_ITEMS; k++) begin
                    send_elem(rand_elem());
                    rnd_items++;
                    elem_gap();
                end
                if (phase == 3 || $urandom_range(0, 9) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYC * 4) @(negedge i_clk);

        $display("covered %0d input beats, %0d results in %0d rotated matrices",
                 n_items, n_results, n_matrices);
        $display("dimension written %0d times, zero and oversize values included, mismatches %0d",
                 n_cfg, err_cnt);
        if (err_cnt == 0 && rot_exp_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("timeout with %0d results outstanding", rot_exp_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
